>>> hdl/tlgr_pkg.sv
// Shared types, constants and the 5x7 font table of the text line glyph rasterizer.
// Depends on nothing; every other file of the block but tlgr_ram imports it.
`default_nettype none

package tlgr_pkg;

    // Geometry of the text store and the panel.
    localparam int LINE_CHARS = 16;
    localparam int ROW_BYTES  = 16;
    localparam int PANEL_ROWS = 296;
    localparam int NUM_LINES  = 3;

    // Glyph geometry: 5x7 glyphs, scaled by two, one blank column per cell.
    localparam int SCALE         = 2;
    localparam int GLYPH_W       = 5;
    localparam int GLYPH_H       = 7;
    localparam int CELL_W        = (GLYPH_W + 1) * SCALE;
    localparam int GLYPH_ROWS_PX = GLYPH_H * SCALE;

    // rx / CELL_W for a 7-bit rx is (rx * 43) >> 9, exact over 0..127.
    localparam int RECIP    = 43;
    localparam int RECIP_SH = 9;

    localparam int STORE_DEPTH = NUM_LINES * LINE_CHARS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Character codes.
    localparam logic [7:0] CODE_BLANK    = 8'h00;
    localparam logic [7:0] CODE_FIRST    = 8'h20;
    localparam logic [7:0] CODE_LAST     = 8'h7E;
    localparam logic [7:0] CODE_FALLBACK = 8'h3F;

    // Input commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_LEFT_MARGIN = 2'd0;
    localparam logic [1:0] REG_LINE1_TOP   = 2'd1;
    localparam logic [1:0] REG_LINE2_TOP   = 2'd2;
    localparam logic [1:0] REG_LINE3_TOP   = 2'd3;

    localparam logic [7:0] BYTE_WHITE = 8'hFF;

    // Result of the cell geometry unit for one pixel of one text line.
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        gx;
        logic [2:0]        gy;
    } t_cell_info;

    // Five glyph columns per entry, column 0 in the top byte; bit 0 is the top row.
    localparam logic [39:0] FONT_ROM [96] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h1008081008, 40'h0006090906
    };

    // One column of one glyph; columns past the glyph are empty.
    function automatic logic [7:0] font_column(input logic [6:0] idx, input logic [2:0] gx);
        logic [39:0] g;
        logic [7:0]  col;
        g = FONT_ROM[idx];
        case (gx)
            3'd0:    col = g[39:32];
            3'd1:    col = g[31:24];
            3'd2:    col = g[23:16];
            3'd3:    col = g[15:8];
            3'd4:    col = g[7:0];
            default: col = 8'h00;
        endcase
        return col;
    endfunction

endpackage

`default_nettype wire

>>> hdl/tlgr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module tlgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/tlgr_cell_unit.sv
// Cell geometry unit: maps one pixel and one text line to a store address and glyph coordinates.
// Depends on tlgr_pkg.
`default_nettype none

module tlgr_cell_unit
    import tlgr_pkg::*;
(
    input  wire logic [6:0] i_x,
    input  wire logic [8:0] i_row,
    input  wire logic [6:0] i_margin,
    input  wire logic [8:0] i_top,
    input  wire logic [1:0] i_line,
    output t_cell_info      o_info
);

    logic [6:0]  rx;
    logic [8:0]  ry;
    logic [13:0] prod;
    logic [3:0]  ci;
    logic [6:0]  rem;
    logic        in_x;
    logic        in_y;

    always_comb begin
        in_x = i_x >= i_margin;
        in_y = i_row >= i_top;
        rx   = i_x - i_margin;
        ry   = i_row - i_top;
        // Division by the cell width through a reciprocal multiply.
        prod = 14'(rx) * 14'(RECIP);
        ci   = 4'(prod >> RECIP_SH);
        rem  = rx - 7'(32'(ci) * CELL_W);

        o_info.hit  = in_x && in_y && (32'(ry) < GLYPH_ROWS_PX) && (32'(ci) < LINE_CHARS);
        o_info.addr = ADDR_W'(32'(i_line) * LINE_CHARS + 32'(ci));
        o_info.gx   = rem[3:1];
        o_info.gy   = ry[3:1];
    end

endmodule

`default_nettype wire

>>> hdl/tlgr_glyph.sv
// Glyph pixel test: says whether a character code covers a given glyph pixel.
// Depends on tlgr_pkg for the font table.
`default_nettype none

module tlgr_glyph
    import tlgr_pkg::*;
(
    input  wire logic [7:0] i_code,
    input  wire logic [2:0] i_gx,
    input  wire logic [2:0] i_gy,
    output logic            o_black
);

    logic [7:0] code;
    logic [6:0] idx;
    logic [7:0] col;

    always_comb begin
        // Unprintable codes draw the question mark; code zero draws nothing.
        code    = (i_code < CODE_FIRST || i_code > CODE_LAST) ? CODE_FALLBACK : i_code;
        idx     = 7'(code - CODE_FIRST);
        col     = font_column(idx, i_gx);
        o_black = (i_code != CODE_BLANK) && (32'(i_gy) < GLYPH_H) && col[i_gy];
    end

endmodule

`default_nettype wire

>>> hdl/text_line_glyph_rasterizer_top.sv
// Top level of the text line glyph rasterizer: sequencer, text store and configuration.
// Depends on tlgr_pkg, tlgr_ram, tlgr_cell_unit and tlgr_glyph.
`default_nettype none

// Three lines of text, sixteen cells each, rendered from a built-in 5x7 font scaled by two
// into 12-pixel cells. A write item (cmd 0) stores one character code; the block can take
// the next item in the following cycle. A fetch item (cmd 1) returns one byte of eight
// pixels, MSB leftmost, with 0 where any line draws a glyph pixel and 1 where the panel
// stays white. A fetch walks the eight pixels and the three lines one at a time through a
// single cell geometry unit and the one read port of the text store; each of the 24 steps
// has an address state, then a data state with the registered store data, and after the
// last step the done state loads the byte into the output register as soon as no earlier
// byte is held downstream. A fetch off the panel goes straight to the done state for its
// all-white byte, and the next item can follow once the block is back in the idle state.
// While a fetch is at work the input channel is stalled. The result sits in an output
// register, so a new item is taken while the previous byte waits for the downstream side.
// Codes outside the printable range draw a question mark, and code zero leaves the cell
// empty. The store is clear after reset without any clearing pass: a valid bit per cell
// covers that. Write the margin and line top registers only while the block is idle.
module text_line_glyph_rasterizer_top
    import tlgr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write port.
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [8:0] i_cfg_data,
    // Input item channel.
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_cmd,
    input  wire logic [1:0] i_line_sel,
    input  wire logic [3:0] i_char_pos,
    input  wire logic [7:0] i_char_code,
    input  wire logic [3:0] i_byte_col,
    input  wire logic [8:0] i_row,
    // Result item channel.
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_pixel_byte
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_DATA,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [6:0] r_left_margin;
    logic [8:0] r_line_top [NUM_LINES];

    // Fetch context and sequencer counters.
    logic [3:0] r_bcol;
    logic [8:0] r_row;
    logic [2:0] r_bit;
    logic [1:0] r_line;
    logic [7:0] r_acc;

    // Step results held between the address and data cycles.
    logic       r_hit;
    logic [2:0] r_gx;
    logic [2:0] r_gy;
    logic       r_rd_valid;

    // One valid bit per text cell; a cell never written reads as blank.
    logic [STORE_DEPTH-1:0] r_cell_valid;

    logic              in_accept;
    logic              wr_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic              off_panel;
    t_cell_info        cell_res;
    logic [7:0]        rd_data;
    logic [7:0]        code;
    logic              black;
    logic              out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;

    // Writes with a line select of three or beyond, or past the line end, are dropped.
    assign wr_ok       = (32'(i_line_sel) < NUM_LINES) && (32'(i_char_pos) < LINE_CHARS);
    assign wr_addr     = ADDR_W'(32'(i_line_sel) * LINE_CHARS + 32'(i_char_pos));
    assign off_panel   = (32'(i_byte_col) >= ROW_BYTES) || (32'(i_row) >= PANEL_ROWS);

    assign code        = r_rd_valid ? rd_data : CODE_BLANK;
    assign out_free    = !o_out_valid || !i_out_stall;

    tlgr_cell_unit u_cell (
        .i_x      ({r_bcol, r_bit}),
        .i_row    (r_row),
        .i_margin (r_left_margin),
        .i_top    (r_line_top[r_line]),
        .i_line   (r_line),
        .o_info   (cell_res)
    );

    tlgr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_accept && (i_cmd == CMD_WRITE) && wr_ok),
        .i_waddr (wr_addr),
        .i_wdata (i_char_code),
        .i_raddr (cell_res.addr),
        .o_rdata (rd_data)
    );

    tlgr_glyph u_glyph (
        .i_code  (code),
        .i_gx    (r_gx),
        .i_gy    (r_gy),
        .o_black (black)
    );

    // Configuration registers take writes at any time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_margin <= 7'd4;
            r_line_top[0] <= 9'd10;
            r_line_top[1] <= 9'd52;
            r_line_top[2] <= 9'd94;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LEFT_MARGIN: r_left_margin <= i_cfg_data[6:0];
                REG_LINE1_TOP:   r_line_top[0] <= i_cfg_data;
                REG_LINE2_TOP:   r_line_top[1] <= i_cfg_data;
                REG_LINE3_TOP:   r_line_top[2] <= i_cfg_data;
                default:         r_left_margin <= r_left_margin;
            endcase
        end
    end

    // Sequencer: state, counters, valid bits and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bit        <= '0;
            r_line       <= '0;
            r_cell_valid <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            // The done state reloads the output register itself.
            if ((r_state != S_DONE) && o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_cmd == CMD_WRITE) begin
                            if (wr_ok) begin
                                r_cell_valid[wr_addr] <= 1'b1;
                            end
                        end else begin
                            r_bcol  <= i_byte_col;
                            r_row   <= i_row;
                            r_bit   <= '0;
                            r_line  <= '0;
                            r_acc   <= BYTE_WHITE;
                            r_state <= off_panel ? S_DONE : S_ADDR;
                        end
                    end
                end
                S_ADDR: begin
                    // The store read is issued at cell_res.addr in this cycle.
                    r_hit      <= cell_res.hit;
                    r_gx       <= cell_res.gx;
                    r_gy       <= cell_res.gy;
                    r_rd_valid <= r_cell_valid[cell_res.addr];
                    r_state    <= S_DATA;
                end
                S_DATA: begin
                    if (r_hit && black) begin
                        r_acc[3'd7 - r_bit] <= 1'b0;
                    end
                    if (32'(r_line) == NUM_LINES - 1) begin
                        r_line <= '0;
                        if (r_bit == 3'd7) begin
                            r_state <= S_DONE;
                        end else begin
                            r_bit   <= r_bit + 3'd1;
                            r_state <= S_ADDR;
                        end
                    end else begin
                        r_line  <= r_line + 2'd1;
                        r_state <= S_ADDR;
                    end
                end
                S_DONE: begin
                    // Wait here only while an earlier byte is still held downstream.
                    if (out_free) begin
                        o_pixel_byte <= r_acc;
                        o_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A write item never brings up a result.
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_cmd == CMD_WRITE) |=> !$rose(o_out_valid))
        else $error("write item produced a result");

    // A fetch item keeps the input channel stalled in the next cycle.
    a_fetch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_cmd == CMD_FETCH) |=> o_in_stall)
        else $error("fetch item did not hold off the input channel");

    // The line counter stays within the three text lines.
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR) |-> (32'(r_line) < NUM_LINES))
        else $error("line counter out of range");

    // A byte is loaded into the output register only when the register is free.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && o_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result overwrote a pending byte");

endmodule

`default_nettype wire

>>> tb/text_line_glyph_rasterizer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of text_line_glyph_rasterizer_top: directed and random items
// against a scoreboard that renders each fetched pixel byte. Depends on tlgr_pkg and the RTL.

import tlgr_pkg::*;

// One input item as driven on the block's ports.
typedef struct packed {
    logic       cmd;
    logic [1:0] line_sel;
    logic [3:0] char_pos;
    logic [7:0] char_code;
    logic [3:0] byte_col;
    logic [8:0] row;
} t_glyph_req;

// One expected pixel byte, with the fetch that asked for it for the error report.
typedef struct packed {
    logic [7:0] pixels;
    logic [3:0] byte_col;
    logic [8:0] row;
} t_fetch_expect;

// Keeps its own copy of the text store and the registers, renders the byte each fetch
// must return and checks the bytes that come out, oldest first.
class pixel_byte_scoreboard;
    logic [7:0]    text_cells [3][16];
    logic [6:0]    margin;
    logic [8:0]    line_top [3];
    t_fetch_expect expected_bytes [$];
    int            mismatches;

    function new();
        for (int l = 0; l < 3; l++)
            for (int p = 0; p < 16; p++)
                text_cells[l][p] = CODE_BLANK;
        margin      = 7'd4;
        line_top[0] = 9'd10;
        line_top[1] = 9'd52;
        line_top[2] = 9'd94;
        mismatches  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] data);
        case (idx)
            REG_LEFT_MARGIN: margin = data[6:0];
            REG_LINE1_TOP:   line_top[0] = data;
            REG_LINE2_TOP:   line_top[1] = data;
            REG_LINE3_TOP:   line_top[2] = data;
            default: ;
        endcase
    endfunction

    // Five columns of a glyph, column 0 in the top byte, bit 0 of a column is the top row.
    function logic [39:0] glyph_columns(logic [6:0] idx);
        logic [39:0] g;
        case (idx)
            7'd0:  g = 40'h0000000000; 7'd1:  g = 40'h00005F0000; 7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147F147F14; 7'd4:  g = 40'h242A7F2A12; 7'd5:  g = 40'h2313086462;
            7'd6:  g = 40'h3649552250; 7'd7:  g = 40'h0005030000; 7'd8:  g = 40'h001C224100;
            7'd9:  g = 40'h0041221C00; 7'd10: g = 40'h14083E0814; 7'd11: g = 40'h08083E0808;
            7'd12: g = 40'h0050300000; 7'd13: g = 40'h0808080808; 7'd14: g = 40'h0060600000;
            7'd15: g = 40'h2010080402; 7'd16: g = 40'h3E5149453E; 7'd17: g = 40'h00427F4000;
            7'd18: g = 40'h4261514946; 7'd19: g = 40'h2141454B31; 7'd20: g = 40'h1814127F10;
            7'd21: g = 40'h2745454539; 7'd22: g = 40'h3C4A494930; 7'd23: g = 40'h0171090503;
            7'd24: g = 40'h3649494936; 7'd25: g = 40'h064949291E; 7'd26: g = 40'h0036360000;
            7'd27: g = 40'h0056360000; 7'd28: g = 40'h0814224100; 7'd29: g = 40'h1414141414;
            7'd30: g = 40'h0041221408; 7'd31: g = 40'h0201510906; 7'd32: g = 40'h324979413E;
            7'd33: g = 40'h7E1111117E; 7'd34: g = 40'h7F49494936; 7'd35: g = 40'h3E41414122;
            7'd36: g = 40'h7F4141221C; 7'd37: g = 40'h7F49494941; 7'd38: g = 40'h7F09090901;
            7'd39: g = 40'h3E4149497A; 7'd40: g = 40'h7F0808087F; 7'd41: g = 40'h00417F4100;
            7'd42: g = 40'h2040413F01; 7'd43: g = 40'h7F08142241; 7'd44: g = 40'h7F40404040;
            7'd45: g = 40'h7F020C027F; 7'd46: g = 40'h7F0408107F; 7'd47: g = 40'h3E4141413E;
            7'd48: g = 40'h7F09090906; 7'd49: g = 40'h3E4151215E; 7'd50: g = 40'h7F09192946;
            7'd51: g = 40'h4649494931; 7'd52: g = 40'h01017F0101; 7'd53: g = 40'h3F4040403F;
            7'd54: g = 40'h1F2040201F; 7'd55: g = 40'h3F4038403F; 7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0708700807; 7'd58: g = 40'h6151494543; 7'd59: g = 40'h007F414100;
            7'd60: g = 40'h0204081020; 7'd61: g = 40'h0041417F00; 7'd62: g = 40'h0402010204;
            7'd63: g = 40'h4040404040; 7'd64: g = 40'h0001020400; 7'd65: g = 40'h2054545478;
            7'd66: g = 40'h7F48444438; 7'd67: g = 40'h3844444420; 7'd68: g = 40'h384444487F;
            7'd69: g = 40'h3854545418; 7'd70: g = 40'h087E090102; 7'd71: g = 40'h0C5252523E;
            7'd72: g = 40'h7F08040478; 7'd73: g = 40'h00447D4000; 7'd74: g = 40'h2040443D00;
            7'd75: g = 40'h7F10284400; 7'd76: g = 40'h00417F4000; 7'd77: g = 40'h7C04180478;
            7'd78: g = 40'h7C08040478; 7'd79: g = 40'h3844444438; 7'd80: g = 40'h7C14141408;
            7'd81: g = 40'h081414187C; 7'd82: g = 40'h7C08040408; 7'd83: g = 40'h4854545420;
            7'd84: g = 40'h043F444020; 7'd85: g = 40'h3C4040207C; 7'd86: g = 40'h1C2040201C;
            7'd87: g = 40'h3C4030403C; 7'd88: g = 40'h4428102844; 7'd89: g = 40'h0C5050503C;
            7'd90: g = 40'h4464544C44; 7'd91: g = 40'h0008364100; 7'd92: g = 40'h00007F0000;
            7'd93: g = 40'h0041360800; 7'd94: g = 40'h1008081008; 7'd95: g = 40'h0006090906;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

    // A write updates the store; a fetch renders its byte and queues it.
    function void note_item(t_glyph_req req);
        t_fetch_expect exp_byte;
        logic [7:0]    code;
        logic [39:0]   glyph;
        int            b, ln, x, rx, ry, cell_idx, gx, gy;
        bit            black;
        if (req.cmd == CMD_WRITE) begin
            if (req.line_sel < 2'd3 && int'(req.char_pos) < LINE_CHARS)
                text_cells[req.line_sel][req.char_pos] = req.char_code;
            return;
        end
        exp_byte.pixels   = BYTE_WHITE;
        exp_byte.byte_col = req.byte_col;
        exp_byte.row      = req.row;
        if (int'(req.byte_col) < ROW_BYTES && int'(req.row) < PANEL_ROWS) begin
            for (b = 0; b < 8; b++) begin
                x     = int'(req.byte_col) * 8 + b;
                black = 1'b0;
                // A pixel is black as soon as any of the three lines draws there.
                for (ln = 0; ln < 3; ln++) begin
                    rx = x - int'(margin);
                    ry = int'(req.row) - int'(line_top[ln]);
                    if (rx >= 0 && ry >= 0 && ry < GLYPH_H * SCALE) begin
                        cell_idx = rx / CELL_W;
                        gx       = (rx % CELL_W) / SCALE;
                        gy       = ry / SCALE;
                        if (cell_idx < LINE_CHARS && gx < GLYPH_W) begin
                            code = text_cells[ln][cell_idx];
                            if (code != CODE_BLANK) begin
                                if (code < CODE_FIRST || code > CODE_LAST)
                                    code = CODE_FALLBACK;
                                glyph = glyph_columns(7'(code - CODE_FIRST));
                                if (glyph[(4 - gx) * 8 + gy])
                                    black = 1'b1;
                            end
                        end
                    end
                end
                if (black)
                    exp_byte.pixels[7 - b] = 1'b0;
            end
        end
        expected_bytes.push_back(exp_byte);
    endfunction

    function void check_pixel_byte(logic [7:0] got);
        t_fetch_expect want;
        if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: pixel byte %02h came out with no fetch outstanding", got);
            return;
        end
        want = expected_bytes.pop_front();
        if (got !== want.pixels) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: fetch col %0d row %0d: pixel byte expected %02h, got %02h",
                         want.byte_col, want.row, want.pixels, got);
        end
    endfunction
endclass

module text_line_glyph_rasterizer_top_tb;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [8:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_cmd;
    logic [1:0] i_line_sel;
    logic [3:0] i_char_pos;
    logic [7:0] i_char_code;
    logic [3:0] i_byte_col;
    logic [8:0] i_row;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_pixel_byte;

    pixel_byte_scoreboard sb;

    // Idle rates in percent. The sender's rate is only touched by the main process; the
    // receiver's rate is handed over with a nonblocking write.
    int src_idle_pct;
    int sink_idle_pct;

    // The main process bumps the request count to ask the receiver for a long hold-off;
    // the receiver counts the stalled cycles itself.
    int hold_req_count;
    int hold_seen;
    int hold_left;

    text_line_glyph_rasterizer_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_line_sel   (i_line_sel),
        .i_char_pos   (i_char_pos),
        .i_char_code  (i_char_code),
        .i_byte_col   (i_byte_col),
        .i_row        (i_row),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_byte (o_pixel_byte)
    );

    always #4 i_clk = ~i_clk;

    // Receiver: a byte is taken at an edge where valid is high and our stall was low.
    // The values read here are the ones from before the edge, so the check does not
    // depend on the order of processes within the time step.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_pixel_byte(o_pixel_byte);
        if (hold_req_count != hold_seen) begin
            hold_seen = hold_req_count;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // A write item; the fetch fields carry random bits the block must ignore.
    function automatic t_glyph_req write_req(logic [1:0] line_sel, logic [3:0] pos,
                                             logic [7:0] code);
        t_glyph_req  r;
        logic [31:0] rnd;
        rnd         = $urandom;
        r.cmd       = CMD_WRITE;
        r.line_sel  = line_sel;
        r.char_pos  = pos;
        r.char_code = code;
        r.byte_col  = rnd[3:0];
        r.row       = rnd[12:4];
        return r;
    endfunction

    // A fetch item; the write fields carry random bits the block must ignore.
    function automatic t_glyph_req fetch_req(logic [3:0] col, logic [8:0] row);
        t_glyph_req  r;
        logic [31:0] rnd;
        rnd         = $urandom;
        r.cmd       = CMD_FETCH;
        r.line_sel  = rnd[1:0];
        r.char_pos  = rnd[5:2];
        r.char_code = rnd[13:6];
        r.byte_col  = col;
        r.row       = row;
        return r;
    endfunction

    // Random traffic: about a third writes that build up text, mostly printable codes, and
    // the rest fetches, most of which land inside or just around a text line's band.
    function automatic t_glyph_req random_req();
        t_glyph_req  r;
        logic [31:0] rnd;
        logic [31:0] v;
        int          ln;
        rnd = $urandom;
        if ($urandom_range(99) < 35) begin
            if ($urandom_range(99) < 75)
                v = $urandom_range(32'h20, 32'h7E);
            else if ($urandom_range(99) < 40)
                v = 32'(CODE_BLANK);
            else
                v = $urandom;
            ln = ($urandom_range(99) < 5) ? 3 : int'($urandom_range(2));
            r  = write_req(2'(ln), rnd[3:0], v[7:0]);
        end else begin
            if ($urandom_range(99) < 80) begin
                ln = int'($urandom_range(2));
                v  = 32'(sb.line_top[ln]) + $urandom_range(0, 15) - 32'd1;
            end else begin
                v = $urandom;
            end
            r = fetch_req(rnd[3:0], v[8:0]);
        end
        return r;
    endfunction

    task automatic send_item(input t_glyph_req req);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= req.cmd;
        i_line_sel  <= req.line_sel;
        i_char_pos  <= req.char_pos;
        i_char_code <= req.char_code;
        i_byte_col  <= req.byte_col;
        i_row       <= req.row;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(req);
    endtask

    // Stops offering items and waits for every outstanding byte. Writes cause no byte, so
    // a settle time longer than a fetch holds the input follows before any register write.
    task automatic wait_results_done(input int settle_cycles);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_bytes.size() != 0);
        repeat (settle_cycles) @(posedge i_clk);
    endtask

    // Writes all four registers on back-to-back cycles; only called while the block is idle.
    task automatic set_config(input logic [8:0] margin_data, input logic [8:0] top1,
                              input logic [8:0] top2, input logic [8:0] top3);
        logic [1:0] idx  [4];
        logic [8:0] vals [4];
        idx  = '{REG_LEFT_MARGIN, REG_LINE1_TOP, REG_LINE2_TOP, REG_LINE3_TOP};
        vals = '{margin_data, top1, top2, top3};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            sb.write_reg(idx[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int          seg;
        int          n;
        logic [31:0] m;
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_LEFT_MARGIN;
        i_cfg_data     = 9'd0;
        i_in_valid     = 1'b0;
        i_cmd          = CMD_WRITE;
        i_line_sel     = 2'd0;
        i_char_pos     = 4'd0;
        i_char_code    = CODE_BLANK;
        i_byte_col     = 4'd0;
        i_row          = 9'd0;
        i_out_stall    = 1'b0;
        hold_req_count = 0;
        hold_seen      = 0;
        hold_left      = 0;
        src_idle_pct   = 15;
        sink_idle_pct  = 88;
        sb             = new();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with the registers still at their reset values
        // (margin 4, line tops 10, 52 and 94).
        send_item(write_req(2'd0, 4'd0, 8'h41));
        send_item(write_req(2'd0, 4'd1, CODE_LAST));
        // Unprintable codes above and below the printable range all draw a question mark.
        send_item(write_req(2'd1, 4'd0, 8'hFF));
        send_item(write_req(2'd1, 4'd1, 8'h1F));
        send_item(write_req(2'd1, 4'd2, 8'h7F));
        // A cell written and then cleared back to blank.
        send_item(write_req(2'd2, 4'd0, 8'h4D));
        send_item(write_req(2'd2, 4'd0, CODE_BLANK));
        send_item(write_req(2'd2, 4'd15, 8'h5A));
        // Line select 3 is not a line; this write must leave the store alone.
        send_item(write_req(2'd3, 4'd0, 8'h58));
        send_item(fetch_req(4'd0, 9'd10));
        send_item(fetch_req(4'd1, 9'd16));
        send_item(fetch_req(4'd0, 9'd23));
        send_item(fetch_req(4'd0, 9'd24));
        send_item(fetch_req(4'd0, 9'd52));
        send_item(fetch_req(4'd2, 9'd58));
        send_item(fetch_req(4'd0, 9'd94));
        send_item(fetch_req(4'd15, 9'd0));
        send_item(fetch_req(4'd15, 9'd295));
        // Rows past the panel bottom come back all white.
        send_item(fetch_req(4'd0, 9'd296));
        send_item(fetch_req(4'd15, 9'd511));
        send_item(fetch_req(4'd15, 9'd12));

        // Overlapping lines: the first two lines share their band, the third overlaps its lower part.
        wait_results_done(60);
        set_config(9'd0, 9'd30, 9'd30, 9'd36);
        send_item(fetch_req(4'd0, 9'd30));
        send_item(fetch_req(4'd0, 9'd34));
        send_item(fetch_req(4'd0, 9'd38));
        send_item(fetch_req(4'd0, 9'd43));

        // Random part in eight segments, each under its own register setting. Segments
        // 0-2 have a slow receiver, 3-5 a slow sender and 6-7 no idling at all.
        for (seg = 0; seg < 8; seg++) begin
            wait_results_done(60);
            if (seg == 3) begin
                src_idle_pct = 88;
                sink_idle_pct <= 15;
            end else if (seg == 6) begin
                src_idle_pct = 0;
                sink_idle_pct <= 0;
            end
            if (seg == 0) begin
                set_config(9'd0, 9'd0, 9'd14, 9'd28);
            end else if (seg == 1) begin
                // Margin data with the upper bits set must act as a margin of 127.
                set_config(9'h1FF, 9'd511, 9'd295, 9'd282);
            end else begin
                m  = $urandom_range(0, 40);
                if (seg == 2)
                    m = m | 32'h180;
                t1 = $urandom_range(0, 280);
                t2 = ($urandom_range(3) == 0) ? t1 + $urandom_range(0, 13)
                                              : $urandom_range(0, 295);
                t3 = $urandom_range(0, 511);
                set_config(m[8:0], t1[8:0], t2[8:0], t3[8:0]);
            end
            for (n = 0; n < 200; n++) begin
                // Long receiver hold-off while items keep coming, so the input backs up.
                if (n == 70)
                    hold_req_count <= hold_req_count + 1;
                // The sender stops until every outstanding byte has been delivered.
                if (n == 140)
                    wait_results_done(0);
                send_item(random_req());
            end
        end

        wait_results_done(60);
        if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
            $display("text_line_glyph_rasterizer_top verification clean");
        else
            $display("text_line_glyph_rasterizer_top verification failed");
        $finish;
    end

    // Watchdog: a correct run needs well under a millisecond.
    initial begin
        #10_000_000;
        $display("text_line_glyph_rasterizer_top verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/tlgr_pkg.sv
hdl/tlgr_ram.sv
hdl/tlgr_cell_unit.sv
hdl/tlgr_glyph.sv
hdl/text_line_glyph_rasterizer_top.sv
tb/text_line_glyph_rasterizer_top_tb.sv
